[sv/caption_user_data_extractor_unit_assert.svh]
// assertion macros shared by the caption extractor modules
`ifndef CAPTION_USER_DATA_EXTRACTOR_UNIT_ASSERT_SVH
`define CAPTION_USER_DATA_EXTRACTOR_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define CUDE_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// condition implies consequence in the following cycle
`define CUDE_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[sv/cude_pkg.sv]
package cude_pkg;

    typedef enum logic [2:0] {
        PH_HEADER      = 3'd0,
        PH_DVD_GROUP   = 3'd1,
        PH_DVD_EXTRA   = 3'd2,
        PH_ATSC_SKIP   = 3'd3,
        PH_ATSC_TRIPLE = 3'd4,
        PH_IDLE        = 3'd5
    } t_phase;

    localparam logic [7:0] C_DVD_TAG     = 8'h43;
    localparam logic [7:0] C_ATSC_G      = 8'h47;
    localparam logic [7:0] C_ATSC_A      = 8'h41;
    localparam logic [7:0] C_ATSC_9      = 8'h39;
    localparam logic [7:0] C_ATSC_4      = 8'h34;
    localparam logic [7:0] C_ATSC_TYPE   = 8'h03;
    localparam logic [7:0] C_MARK_FIELD  = 8'hff;
    localparam logic [7:0] C_MARK_EXTRA  = 8'hfe;
    localparam logic [2:0] C_DVD_CNT_IDX = 3'd4;
    localparam logic [2:0] C_ATSC_CNT_IDX = 3'd5;
    localparam logic [2:0] C_DVD_LAST_IDX = 3'd5;
    localparam logic [2:0] C_ATSC_LAST_IDX = 3'd2;
    localparam int unsigned GROUP_DEPTH  = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       pair_valid;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       source_format;
        logic       block_end;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result result;
    } t_parse_out;

    // valid type-0 triple with non-padding data
    function automatic logic is_cc1(input logic [7:0] hdr, input logic [7:0] b1,
                                    input logic [7:0] b2);
        logic ok;
        ok = hdr[2] && (hdr[1:0] == 2'b00) && !((b1[6:0] == 7'd0) && (b2[6:0] == 7'd0));
        return ok;
    endfunction

endpackage

[sv/cude_if.sv]
interface cude_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cude_out_if;
    logic       valid;
    logic       ready;
    logic       pair_valid;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       source_format;
    logic       block_end;

    modport source (output valid, output pair_valid, output first_byte, output second_byte,
                    output source_format, output block_end, input ready);
    modport sink   (input valid, input pair_valid, input first_byte, input second_byte,
                    input source_format, input block_end, output ready);
endinterface

[sv/caption_user_data_extractor_unit.sv]
// Caption user-data extractor, CC1 only.
// i_in carries one user-data byte per item (data_byte) with last_byte set on
// the final byte of a picture's user-data block. The header selects DVD style
// (0x43 0x43) or ATSC style (GA94, type 3, process flag) wrapping.
// o_out gives an item when a CC1 byte pair is found (pair_valid set) or at
// block end (block_end set), or both; an item with no pair has zero bytes.
// A result passes from the input register through the parser into the result
// register before it is on o_out.
// Throughput: one byte per cycle while o_out is not held back; the parser state
// is a small set of registers updated once per byte.
// Bytes that cause no result leave no item on o_out.
// Reset (synchronous, active low): the parser returns to its header phase,
// both stages empty. There is no clearing pass.
// When the receiver holds o_out.ready low, one finished item waits in the
// output register and one byte waits in the input register; i_in.ready then
// drops until the output drains.
module caption_user_data_extractor_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cude_in_if.sink    i_in,
    cude_out_if.source o_out
);
    import cude_pkg::*;

    logic       w_valid;
    logic       w_advance;
    logic       w_out_free;
    t_in_item   w_item;
    t_parse_out w_parse;

    cude_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_free (w_out_free),
        .o_valid    (w_valid),
        .o_advance  (w_advance),
        .o_item     (w_item)
    );

    cude_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid),
        .i_advance (w_advance),
        .i_item    (w_item),
        .o_parse   (w_parse)
    );

    cude_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_parse   (w_parse),
        .o_free    (w_out_free),
        .o_out     (o_out)
    );

endmodule

[sv/cude_in_stage.sv]
module cude_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cude_in_if.sink           i_in,
    input  logic              i_out_free,
    output logic              o_valid,
    output logic              o_advance,
    output cude_pkg::t_in_item o_item
);
    import cude_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_take;

    assign o_advance   = r_valid && i_out_free;
    assign i_in.ready  = !r_valid || o_advance;
    assign w_take      = i_in.valid && i_in.ready;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.data_byte <= i_in.data_byte;
            r_item.last_byte <= i_in.last_byte;
        end
    end

endmodule

[sv/cude_parser.sv]
`include "caption_user_data_extractor_unit_assert.svh"

module cude_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_advance,
    input  cude_pkg::t_in_item   i_item,
    output cude_pkg::t_parse_out o_parse
);
    import cude_pkg::*;

    t_phase     r_phase, n_phase;
    logic [2:0] r_byte_index, n_byte_index;
    logic       r_wrapper_kind, n_wrapper_kind;
    logic       r_field_one_second, n_field_one_second;
    logic [4:0] r_groups_left, n_groups_left;
    logic [7:0] r_group_bytes [GROUP_DEPTH];

    logic       w_gb_we;
    logic [7:0] w_b;
    logic       w_dvd_abort;
    logic [4:0] w_groups_dec;
    logic [7:0] w_mark;
    logic [7:0] w_d1;
    logic [7:0] w_d2;
    logic       w_pair;
    logic       w_fmt;

    assign w_b          = i_item.data_byte;
    assign w_groups_dec = r_groups_left - 5'd1;
    assign w_dvd_abort  = (r_phase == PH_DVD_EXTRA) && (r_byte_index == 3'd0) &&
                          (w_b != C_MARK_EXTRA) && (w_b != C_MARK_FIELD);

    // next state
    always_comb begin
        n_phase            = r_phase;
        n_byte_index       = r_byte_index;
        n_wrapper_kind     = r_wrapper_kind;
        n_field_one_second = r_field_one_second;
        n_groups_left      = r_groups_left;
        w_gb_we            = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                n_byte_index = r_byte_index + 3'd1;
                if (r_byte_index == 3'd0) begin
                    if (w_b == C_DVD_TAG) begin
                        n_wrapper_kind = 1'b0;
                    end else if (w_b == C_ATSC_G) begin
                        n_wrapper_kind = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end else if (!r_wrapper_kind) begin
                    if (r_byte_index == 3'd1 && w_b != C_DVD_TAG) begin
                        n_phase = PH_IDLE;
                    end else if (r_byte_index == C_DVD_CNT_IDX) begin
                        n_field_one_second = ~w_b[7];
                        n_groups_left      = {1'b0, w_b[4:1]};
                        n_phase            = (w_b[4:1] != 4'd0) ? PH_DVD_GROUP : PH_DVD_EXTRA;
                        n_byte_index       = 3'd0;
                    end
                end else begin
                    if ((r_byte_index == 3'd1 && w_b != C_ATSC_A) ||
                        (r_byte_index == 3'd2 && w_b != C_ATSC_9) ||
                        (r_byte_index == 3'd3 && w_b != C_ATSC_4) ||
                        (r_byte_index == 3'd4 && w_b != C_ATSC_TYPE) ||
                        (r_byte_index == C_ATSC_CNT_IDX && !w_b[6])) begin
                        n_phase = PH_IDLE;
                    end else if (r_byte_index == C_ATSC_CNT_IDX) begin
                        n_groups_left = w_b[4:0];
                        n_phase       = PH_ATSC_SKIP;
                        n_byte_index  = 3'd0;
                    end else if (r_byte_index > C_ATSC_CNT_IDX) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_DVD_GROUP, PH_DVD_EXTRA: begin
                if (w_dvd_abort) begin
                    n_phase = PH_IDLE;
                end else if (r_byte_index < C_DVD_LAST_IDX) begin
                    w_gb_we      = 1'b1;
                    n_byte_index = r_byte_index + 3'd1;
                end else begin
                    n_byte_index = 3'd0;
                    if (r_phase == PH_DVD_GROUP) begin
                        n_groups_left = w_groups_dec;
                        if (w_groups_dec == 5'd0) begin
                            n_phase = PH_DVD_EXTRA;
                        end
                    end
                end
            end
            PH_ATSC_SKIP: begin
                n_phase      = (r_groups_left != 5'd0) ? PH_ATSC_TRIPLE : PH_IDLE;
                n_byte_index = 3'd0;
            end
            PH_ATSC_TRIPLE: begin
                if (r_byte_index < C_ATSC_LAST_IDX) begin
                    w_gb_we      = 1'b1;
                    n_byte_index = r_byte_index + 3'd1;
                end else begin
                    n_byte_index  = 3'd0;
                    n_groups_left = w_groups_dec;
                    if (w_groups_dec == 5'd0) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_IDLE: begin
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        // block end returns the parser to its start
        if (i_item.last_byte) begin
            n_phase            = PH_HEADER;
            n_byte_index       = 3'd0;
            n_wrapper_kind     = 1'b0;
            n_field_one_second = 1'b0;
            n_groups_left      = 5'd0;
        end
    end

    // outputs
    always_comb begin
        w_pair = 1'b0;
        w_fmt  = 1'b0;
        if (!r_field_one_second) begin
            w_mark = r_group_bytes[0];
            w_d1   = r_group_bytes[1];
            w_d2   = r_group_bytes[2];
        end else begin
            w_mark = r_group_bytes[3];
            w_d1   = r_group_bytes[4];
            w_d2   = w_b;
        end
        if ((r_phase == PH_DVD_GROUP || r_phase == PH_DVD_EXTRA) &&
            r_byte_index == C_DVD_LAST_IDX) begin
            w_pair = is_cc1({5'd0, 2'b10, (w_mark != C_MARK_FIELD)}, w_d1, w_d2);
        end else if (r_phase == PH_ATSC_TRIPLE && r_byte_index == C_ATSC_LAST_IDX) begin
            w_d1   = r_group_bytes[1];
            w_d2   = w_b;
            w_pair = is_cc1(r_group_bytes[0], r_group_bytes[1], w_b);
            w_fmt  = 1'b1;
        end
        o_parse.emit                 = w_pair || i_item.last_byte;
        o_parse.result.pair_valid    = w_pair;
        o_parse.result.first_byte    = w_pair ? w_d1 : 8'd0;
        o_parse.result.second_byte   = w_pair ? w_d2 : 8'd0;
        o_parse.result.source_format = w_pair && w_fmt;
        o_parse.result.block_end     = i_item.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= PH_HEADER;
            r_byte_index       <= 3'd0;
            r_wrapper_kind     <= 1'b0;
            r_field_one_second <= 1'b0;
            r_groups_left      <= 5'd0;
        end else if (i_advance) begin
            r_phase            <= n_phase;
            r_byte_index       <= n_byte_index;
            r_wrapper_kind     <= n_wrapper_kind;
            r_field_one_second <= n_field_one_second;
            r_groups_left      <= n_groups_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && w_gb_we) begin
            r_group_bytes[r_byte_index] <= w_b;
        end
    end

    `CUDE_ASSERT_NEXT(a_block_end_clears, i_clk, i_rst_n, i_advance && i_item.last_byte,
        r_phase == PH_HEADER && r_byte_index == 3'd0 && r_groups_left == 5'd0)
    `CUDE_ASSERT_SAME(a_dvd_index_range, i_clk, i_rst_n,
        r_phase == PH_DVD_GROUP || r_phase == PH_DVD_EXTRA, r_byte_index <= C_DVD_LAST_IDX)
    `CUDE_ASSERT_SAME(a_atsc_pair_source, i_clk, i_rst_n,
        i_valid && o_parse.result.source_format, r_phase == PH_ATSC_TRIPLE)

endmodule

[sv/cude_out_stage.sv]
module cude_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  cude_pkg::t_parse_out i_parse,
    output logic                 o_free,
    cude_out_if.source           o_out
);
    import cude_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    w_load;

    assign o_free = !r_valid || o_out.ready;
    assign w_load = i_advance && i_parse.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_parse.result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.pair_valid    = r_result.pair_valid;
    assign o_out.first_byte    = r_result.first_byte;
    assign o_out.second_byte   = r_result.second_byte;
    assign o_out.source_format = r_result.source_format;
    assign o_out.block_end     = r_result.block_end;

endmodule
